// ===== rtl/wmlp_pkg.sv =====
package wmlp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MIN  = 2'd1,
    PH_MAX  = 2'd2
  } phase_t;

  localparam logic [7:0] FLAG_I32_MIN     = 8'h00;
  localparam logic [7:0] FLAG_I32_MIN_MAX = 8'h01;
  localparam logic [7:0] FLAG_I64_MIN     = 8'h04;
  localparam logic [7:0] FLAG_I64_MIN_MAX = 8'h05;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_I32     = 2'd1;
  localparam logic [1:0] KIND_I64     = 2'd2;

  localparam int unsigned ABSENT_MAX_W = 17;
  localparam logic [ABSENT_MAX_W-1:0] ABSENT_MAX_RESET = 17'd65536;

  localparam logic [3:0] LEB_MAX_BYTES = 4'd10;

  typedef struct packed {
    logic [1:0]  address_kind;
    logic [63:0] min_pages;
    logic [63:0] max_pages;
    logic        overlong_error;
  } result_t;

endpackage

// ===== rtl/wmlp_parser.sv =====
module wmlp_parser
  import wmlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [7:0]              data_byte,
  input  logic                    entry_start,
  input  logic [ABSENT_MAX_W-1:0] absent_max,
  output logic                    res_valid,
  output result_t                 res
);

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        max_follows_r, max_follows_nxt;
  logic [63:0] min_r, min_nxt;

  logic [6:0]  payload;
  logic        more;
  logic [6:0]  shamt;
  logic [63:0] acc_upd;
  logic [3:0]  cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      acc_r         <= '0;
      cnt_r         <= '0;
      kind_r        <= KIND_INVALID;
      max_follows_r <= 1'b0;
      min_r         <= '0;
    end else begin
      phase_r       <= phase_nxt;
      acc_r         <= acc_nxt;
      cnt_r         <= cnt_nxt;
      kind_r        <= kind_nxt;
      max_follows_r <= max_follows_nxt;
      min_r         <= min_nxt;
    end
  end

  assign payload = data_byte[6:0];
  assign more    = data_byte[7];
  assign shamt   = {cnt_r, 3'b000} - {3'b000, cnt_r};
  assign acc_upd = (cnt_r < LEB_MAX_BYTES) ? (acc_r | ({57'd0, payload} << shamt)) : acc_r;
  assign cnt_inc = cnt_r + 4'd1;

  always_comb begin
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    kind_nxt        = kind_r;
    max_follows_nxt = max_follows_r;
    min_nxt         = min_r;
    res_valid       = 1'b0;
    res             = '0;
    if (accept) begin
      if (entry_start) begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        min_nxt   = '0;
        phase_nxt = PH_MIN;
        unique case (data_byte)
          FLAG_I32_MIN: begin
            kind_nxt        = KIND_I32;
            max_follows_nxt = 1'b0;
          end
          FLAG_I32_MIN_MAX: begin
            kind_nxt        = KIND_I32;
            max_follows_nxt = 1'b1;
          end
          FLAG_I64_MIN: begin
            kind_nxt        = KIND_I64;
            max_follows_nxt = 1'b0;
          end
          FLAG_I64_MIN_MAX: begin
            kind_nxt        = KIND_I64;
            max_follows_nxt = 1'b1;
          end
          default: begin
            kind_nxt        = KIND_INVALID;
            max_follows_nxt = 1'b0;
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
          end
        endcase
      end else if (phase_r == PH_MIN || phase_r == PH_MAX) begin
        if (more) begin
          if (cnt_inc >= LEB_MAX_BYTES) begin
            phase_nxt          = PH_IDLE;
            acc_nxt            = '0;
            cnt_nxt            = '0;
            res_valid          = 1'b1;
            res.address_kind   = kind_r;
            res.overlong_error = 1'b1;
          end else begin
            acc_nxt = acc_upd;
            cnt_nxt = cnt_inc;
          end
        end else if (phase_r == PH_MIN && max_follows_r) begin
          min_nxt   = acc_upd;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_MAX;
        end else begin
          phase_nxt        = PH_IDLE;
          acc_nxt          = '0;
          cnt_nxt          = '0;
          res_valid        = 1'b1;
          res.address_kind = kind_r;
          if (phase_r == PH_MIN) begin
            res.min_pages = acc_upd;
            res.max_pages = {{(64-ABSENT_MAX_W){1'b0}}, absent_max};
          end else begin
            res.min_pages = min_r;
            res.max_pages = acc_upd;
          end
        end
      end
    end
  end

  // A result only ever comes from a transfer on the input side.
  assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> accept)
    else $error("result produced without an input transfer");

  // Stray bytes outside an entry must never produce a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !entry_start && phase_r == PH_IDLE) |-> !res_valid)
    else $error("result produced for a byte outside an entry");

  // An overlong value aborts the entry and the parser goes back to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.overlong_error) |=> (phase_r == PH_IDLE && cnt_r == 4'd0))
    else $error("parser did not return to idle after an overlong value");

endmodule

// ===== rtl/wmlp_out_buf.sv =====
module wmlp_out_buf
  import wmlp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The input side is held off whenever both entries are occupied.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("result written into a full output buffer");

  // The occupancy never reaches three and stays in step with the pointers.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 2'd3) && (out_valid == (wr_ptr_r != rd_ptr_r || full)))
    else $error("output buffer occupancy out of step with its pointers");

endmodule

// ===== rtl/wasm_memory_limits_parser_top.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_data_byte, in_entry_start
// result    out_valid / out_stall  out_address_kind, out_min_pages, out_max_pages,
//                                  out_overlong_error
// config    cfg_wr_en              cfg_wr_data (absent maximum page count)
//
// One input byte is taken every cycle while in_stall is low, and the parse state is
// updated in the same cycle. The byte that ends a result writes it into a two-entry
// output buffer, read in order, so input stalls only once two results are waiting.
// Synchronous active-low reset clears the parser and the buffer and sets the absent
// maximum to 65536.
module wasm_memory_limits_parser_top
  import wmlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_entry_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_address_kind,
  output logic [63:0]             out_min_pages,
  output logic [63:0]             out_max_pages,
  output logic                    out_overlong_error,
  input  logic                    cfg_wr_en,
  input  logic [ABSENT_MAX_W-1:0] cfg_wr_data
);

  logic [ABSENT_MAX_W-1:0] absent_max_r;
  logic                    accept;
  logic                    full;
  logic                    res_valid;
  result_t                 res;
  result_t                 out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      absent_max_r <= ABSENT_MAX_RESET;
    end else if (cfg_wr_en) begin
      absent_max_r <= cfg_wr_data;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  wmlp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .entry_start (in_entry_start),
    .absent_max  (absent_max_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  wmlp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_address_kind   = out_data.address_kind;
  assign out_min_pages      = out_data.min_pages;
  assign out_max_pages      = out_data.max_pages;
  assign out_overlong_error = out_data.overlong_error;

endmodule
